// ===== rtl/ialu_pkg.sv =====
package ialu_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned SizeW = 2;
  localparam int unsigned DataW = 64;
  localparam int unsigned FlagW = 6;

  // operation codes
  localparam logic [KindW-1:0] KIND_MOV  = 5'd0;
  localparam logic [KindW-1:0] KIND_ADD  = 5'd1;
  localparam logic [KindW-1:0] KIND_SUB  = 5'd2;
  localparam logic [KindW-1:0] KIND_CMP  = 5'd3;
  localparam logic [KindW-1:0] KIND_AND  = 5'd4;
  localparam logic [KindW-1:0] KIND_OR   = 5'd5;
  localparam logic [KindW-1:0] KIND_XOR  = 5'd6;
  localparam logic [KindW-1:0] KIND_TEST = 5'd7;
  localparam logic [KindW-1:0] KIND_NEG  = 5'd8;
  localparam logic [KindW-1:0] KIND_SHL  = 5'd9;
  localparam logic [KindW-1:0] KIND_SHR  = 5'd10;
  localparam logic [KindW-1:0] KIND_SAR  = 5'd11;
  localparam logic [KindW-1:0] KIND_JMP  = 5'd12;
  localparam logic [KindW-1:0] KIND_JZ   = 5'd13;
  localparam logic [KindW-1:0] KIND_JNZ  = 5'd14;
  localparam logic [KindW-1:0] KIND_JS   = 5'd15;
  localparam logic [KindW-1:0] KIND_JNS  = 5'd16;
  localparam logic [KindW-1:0] KIND_JP   = 5'd17;
  localparam logic [KindW-1:0] KIND_JNP  = 5'd18;
  localparam logic [KindW-1:0] KIND_JB   = 5'd19;
  localparam logic [KindW-1:0] KIND_JAE  = 5'd20;
  localparam logic [KindW-1:0] KIND_JBE  = 5'd21;
  localparam logic [KindW-1:0] KIND_JA   = 5'd22;
  localparam logic [KindW-1:0] KIND_JL   = 5'd23;
  localparam logic [KindW-1:0] KIND_JGE  = 5'd24;
  localparam logic [KindW-1:0] KIND_JLE  = 5'd25;
  localparam logic [KindW-1:0] KIND_JG   = 5'd26;

  // operand size codes
  localparam logic [SizeW-1:0] SIZE_8  = 2'd0;
  localparam logic [SizeW-1:0] SIZE_16 = 2'd1;
  localparam logic [SizeW-1:0] SIZE_32 = 2'd2;
  localparam logic [SizeW-1:0] SIZE_64 = 2'd3;

  // flag bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_P = 1;
  localparam int unsigned FL_A = 2;
  localparam int unsigned FL_Z = 3;
  localparam int unsigned FL_S = 4;
  localparam int unsigned FL_O = 5;

  typedef logic [DataW-1:0] data_t;
  typedef logic [FlagW-1:0] flags_t;

  // top bit of a value at the operand width
  function automatic logic msb_at(input data_t v, input logic [SizeW-1:0] sz);
    logic r;
    case (sz)
      SIZE_8:  r = v[7];
      SIZE_16: r = v[15];
      SIZE_32: r = v[31];
      default: r = v[63];
    endcase
    return r;
  endfunction

  // zero, sign and parity of a masked result
  function automatic flags_t zsp(input data_t v, input logic [SizeW-1:0] sz);
    flags_t f;
    f       = '0;
    f[FL_Z] = (v == '0);
    f[FL_S] = msb_at(v, sz);
    f[FL_P] = ~^v[7:0];
    return f;
  endfunction

endpackage

// ===== rtl/integer_alu_with_flags_and_branch.sv =====
// Integer ALU with x86 status flags and branch resolution. Each beat on the
// in_ channel carries one instruction (move, add, sub, cmp, and, or, xor,
// test, neg, shl, shr, sar or one of fifteen jumps) with its operands; each
// beat on the out_ channel carries the destination value, the write enable,
// the branch decision and target, and the six flags after the instruction.
// One instruction is accepted per clock when the consumer keeps up; each
// passes through the input register, then the result register. The rate
// is set by the loop through the held flags: the ALU reads them from the
// flag register and writes them back on the same edge that moves its result
// into the output register, so the next instruction sees them at once.
// The flags clear on reset. Shift counts are masked to 6 bits at 64-bit width
// and to 5 bits otherwise; a zero count leaves the value and flags alone.
module integer_alu_with_flags_and_branch
  import ialu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // instruction channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KindW-1:0] in_kind,
  input  logic [SizeW-1:0] in_size_code,
  input  logic [DataW-1:0] in_first_value,
  input  logic [DataW-1:0] in_second_value,
  input  logic [DataW-1:0] in_next_pointer,
  input  logic             in_relative,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_result_value,
  output logic             out_write_result,
  output logic             out_branch_taken,
  output logic [DataW-1:0] out_branch_target,
  output logic [FlagW-1:0] out_flags_out
);

  // input register
  logic             s1_valid_r;
  logic [KindW-1:0] s1_kind_r;
  logic [SizeW-1:0] s1_size_r;
  data_t            s1_first_r;
  data_t            s1_second_r;
  data_t            s1_nip_r;
  logic             s1_rel_r;

  // result register
  logic             out_valid_r;
  data_t            res_r;
  logic             wr_r;
  logic             tk_r;
  data_t            tgt_r;
  flags_t           flags_r;   // architectural flags, also shown on the result beat

  logic             advance;
  logic             s1_load;

  // alu results
  data_t            res_nxt;
  logic             wr_nxt;
  logic             tk_nxt;
  data_t            tgt_nxt;
  flags_t           flags_nxt;

  // the result register frees up when empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load) begin
      s1_kind_r   <= in_kind;
      s1_size_r   <= in_size_code;
      s1_first_r  <= in_first_value;
      s1_second_r <= in_second_value;
      s1_nip_r    <= in_next_pointer;
      s1_rel_r    <= in_relative;
    end
  end

  // execute
  always_comb begin
    data_t            msk;
    data_t            a;
    data_t            b;
    data_t            a_sx;
    logic [DataW:0]   sum;
    logic [DataW:0]   diff;
    logic             add_c;
    data_t            logic_v;
    logic [5:0]       cnt;
    logic [6:0]       wbits;
    logic [6:0]       shl_idx;
    logic [5:0]       cnt_m1;
    logic             cf;
    logic             cond;
    logic             fc;
    logic             fz;
    logic             fs;
    logic             fo;
    logic             fp;

    case (s1_size_r)
      SIZE_8: begin
        msk   = 64'h0000_0000_0000_00ff;
        add_c = 1'b0;
      end
      SIZE_16: begin
        msk   = 64'h0000_0000_0000_ffff;
        add_c = 1'b0;
      end
      SIZE_32: begin
        msk   = 64'h0000_0000_ffff_ffff;
        add_c = 1'b0;
      end
      default: begin
        msk   = '1;
        add_c = 1'b0;
      end
    endcase

    a    = s1_first_r & msk;
    b    = s1_second_r & msk;
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};

    // carry out of the operand width
    case (s1_size_r)
      SIZE_8:  add_c = sum[8];
      SIZE_16: add_c = sum[16];
      SIZE_32: add_c = sum[32];
      default: add_c = sum[64];
    endcase

    case (s1_size_r)
      SIZE_8:  a_sx = {{56{a[7]}}, a[7:0]};
      SIZE_16: a_sx = {{48{a[15]}}, a[15:0]};
      SIZE_32: a_sx = {{32{a[31]}}, a[31:0]};
      default: a_sx = a;
    endcase

    // masked shift count
    cnt     = (s1_size_r == SIZE_64) ? s1_second_r[5:0] : {1'b0, s1_second_r[4:0]};
    wbits   = 7'd8 << s1_size_r;
    shl_idx = wbits - {1'b0, cnt};
    cnt_m1  = cnt - 6'd1;

    case (s1_kind_r)
      KIND_OR:  logic_v = a | b;
      KIND_XOR: logic_v = a ^ b;
      default:  logic_v = a & b;
    endcase

    fc   = flags_r[FL_C];
    fz   = flags_r[FL_Z];
    fs   = flags_r[FL_S];
    fo   = flags_r[FL_O];
    fp   = flags_r[FL_P];
    cf   = 1'b0;
    cond = 1'b0;

    res_nxt   = '0;
    wr_nxt    = 1'b0;
    tk_nxt    = 1'b0;
    tgt_nxt   = s1_nip_r;
    flags_nxt = flags_r;

    case (s1_kind_r)
      KIND_MOV: begin
        res_nxt = b;
        wr_nxt  = 1'b1;
      end
      KIND_ADD: begin
        res_nxt         = sum[DataW-1:0] & msk;
        wr_nxt          = 1'b1;
        flags_nxt       = zsp(res_nxt, s1_size_r);
        flags_nxt[FL_C] = add_c;
        flags_nxt[FL_A] = a[4] ^ b[4] ^ res_nxt[4];
        flags_nxt[FL_O] = msb_at((a ^ res_nxt) & (b ^ res_nxt), s1_size_r);
      end
      KIND_SUB, KIND_CMP: begin
        flags_nxt       = zsp(diff[DataW-1:0] & msk, s1_size_r);
        flags_nxt[FL_C] = diff[DataW];   // borrow
        flags_nxt[FL_A] = a[4] ^ b[4] ^ diff[4];
        flags_nxt[FL_O] = msb_at((a ^ b) & (a ^ diff[DataW-1:0]), s1_size_r);
        if (s1_kind_r == KIND_SUB) begin
          res_nxt = diff[DataW-1:0] & msk;
          wr_nxt  = 1'b1;
        end
      end
      KIND_AND, KIND_OR, KIND_XOR, KIND_TEST: begin
        // adjust is kept, carry and overflow cleared
        flags_nxt       = zsp(logic_v, s1_size_r);
        flags_nxt[FL_A] = flags_r[FL_A];
        if (s1_kind_r != KIND_TEST) begin
          res_nxt = logic_v;
          wr_nxt  = 1'b1;
        end
      end
      KIND_NEG: begin
        res_nxt = (~a + 64'd1) & msk;
        wr_nxt  = 1'b1;
      end
      KIND_SHL, KIND_SHR, KIND_SAR: begin
        wr_nxt = 1'b1;
        if (cnt == 6'd0) begin
          res_nxt = a;
        end else begin
          case (s1_kind_r)
            KIND_SHL: begin
              res_nxt = (a << cnt) & msk;
              // last bit out the top; nothing once the count passes the width
              cf      = (shl_idx[6] == 1'b0) ? a[shl_idx[5:0]] : 1'b0;
              if (cnt > wbits[5:0] && s1_size_r != SIZE_64) begin
                cf = 1'b0;
              end
            end
            KIND_SHR: begin
              res_nxt = a >> cnt;
              cf      = a[cnt_m1];
            end
            default: begin
              res_nxt = data_t'($signed(a_sx) >>> cnt) & msk;
              cf      = a_sx[cnt_m1];
            end
          endcase
          flags_nxt[FL_C] = cf;
        end
      end
      KIND_JMP, KIND_JZ, KIND_JNZ, KIND_JS, KIND_JNS, KIND_JP, KIND_JNP,
      KIND_JB, KIND_JAE, KIND_JBE, KIND_JA, KIND_JL, KIND_JGE, KIND_JLE,
      KIND_JG: begin
        case (s1_kind_r)
          KIND_JMP: cond = 1'b1;
          KIND_JZ:  cond = fz;
          KIND_JNZ: cond = !fz;
          KIND_JS:  cond = fs;
          KIND_JNS: cond = !fs;
          KIND_JP:  cond = fp;
          KIND_JNP: cond = !fp;
          KIND_JB:  cond = fc;
          KIND_JAE: cond = !fc;
          KIND_JBE: cond = fc || fz;
          KIND_JA:  cond = !fc && !fz;
          KIND_JL:  cond = fs != fo;
          KIND_JGE: cond = fs == fo;
          KIND_JLE: cond = fz || (fs != fo);
          default:  cond = !fz && (fs == fo);
        endcase
        if (cond) begin
          tk_nxt  = 1'b1;
          // full 64-bit offset, wraps at 64 bits
          tgt_nxt = s1_rel_r ? (s1_nip_r + s1_second_r) : s1_second_r;
        end
      end
      default: begin
        // unused codes: no write, no branch, flags held
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      res_r <= res_nxt;
      wr_r  <= wr_nxt;
      tk_r  <= tk_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = res_r;
  assign out_write_result  = wr_r;
  assign out_branch_taken  = tk_r;
  assign out_branch_target = tgt_r;
  assign out_flags_out     = flags_r;

endmodule

// ===== sim/integer_alu_with_flags_and_branch_test.sv =====
`timescale 1ns / 1ps

module integer_alu_with_flags_and_branch_test;
  import ialu_pkg::*;

  // kinds past the last jump do nothing but echo the held flags
  localparam logic [KindW-1:0] KIND_IDLE_FIRST = KIND_JG + 5'd1;
  localparam logic [KindW-1:0] KIND_IDLE_LAST  = '1;

  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned ItemsPerPhase = 300;

  // one instruction beat as it enters the block
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SizeW-1:0] size;
    data_t            first;
    data_t            second;
    data_t            nip;
    logic             rel;
  } instr_t;

  // one result beat as it leaves the block
  typedef struct packed {
    data_t  value;
    logic   wr;
    logic   taken;
    data_t  target;
    flags_t flags;
  } alu_result_t;

  // tracks the flags the block should hold and the results still owed
  class alu_scoreboard;
    flags_t      held_flags = '0;
    alu_result_t awaited_results[$];
    int unsigned mismatches = 0;

    function flags_t zero_sign_parity(input data_t v, input data_t top);
      flags_t f;
      f       = '0;
      f[FL_Z] = (v == '0);
      f[FL_S] = ((v & top) != '0);
      f[FL_P] = ~^v[7:0];
      return f;
    endfunction

    function logic jump_holds(input logic [KindW-1:0] kind, input flags_t f);
      logic r;
      case (kind)
        KIND_JMP: r = 1'b1;
        KIND_JZ:  r = f[FL_Z];
        KIND_JNZ: r = !f[FL_Z];
        KIND_JS:  r = f[FL_S];
        KIND_JNS: r = !f[FL_S];
        KIND_JP:  r = f[FL_P];
        KIND_JNP: r = !f[FL_P];
        KIND_JB:  r = f[FL_C];
        KIND_JAE: r = !f[FL_C];
        KIND_JBE: r = f[FL_C] || f[FL_Z];
        KIND_JA:  r = !f[FL_C] && !f[FL_Z];
        KIND_JL:  r = f[FL_S] != f[FL_O];
        KIND_JGE: r = f[FL_S] == f[FL_O];
        KIND_JLE: r = f[FL_Z] || (f[FL_S] != f[FL_O]);
        KIND_JG:  r = !f[FL_Z] && (f[FL_S] == f[FL_O]);
        default:  r = 1'b0;
      endcase
      return r;
    endfunction

    // executes one instruction against the held flags and advances them
    function alu_result_t execute(input instr_t it);
      alu_result_t r;
      int unsigned w;
      int unsigned cnt;
      data_t       msk, top, a, b, d, carries;
      logic        neg, cf, adj;
      flags_t      f;
      case (it.size)
        SIZE_8:  w = 8;
        SIZE_16: w = 16;
        SIZE_32: w = 32;
        default: w = 64;
      endcase
      msk      = (w == 64) ? '1 : ((data_t'(1) << w) - data_t'(1));
      top      = data_t'(1) << (w - 1);
      a        = it.first & msk;
      b        = it.second & msk;
      f        = held_flags;
      r.value  = '0;
      r.wr     = 1'b0;
      r.taken  = 1'b0;
      r.target = it.nip;
      case (it.kind)
        KIND_MOV: begin
          r.value = b;
          r.wr    = 1'b1;
        end
        KIND_ADD: begin
          d       = (a + b) & msk;
          carries = a ^ b ^ d;
          f       = zero_sign_parity(d, top);
          f[FL_C] = (d < a);
          f[FL_A] = carries[4];
          f[FL_O] = (((a ^ d) & (b ^ d) & top) != '0);
          r.value = d;
          r.wr    = 1'b1;
        end
        KIND_SUB, KIND_CMP: begin
          d       = (a - b) & msk;
          carries = a ^ b ^ d;
          f       = zero_sign_parity(d, top);
          f[FL_C] = (a < b);
          f[FL_A] = carries[4];
          f[FL_O] = (((a ^ b) & (a ^ d) & top) != '0);
          if (it.kind == KIND_SUB) begin
            r.value = d;
            r.wr    = 1'b1;
          end
        end
        KIND_AND, KIND_OR, KIND_XOR, KIND_TEST: begin
          d       = (it.kind == KIND_OR) ? (a | b) : (it.kind == KIND_XOR) ? (a ^ b) : (a & b);
          adj     = f[FL_A];
          f       = zero_sign_parity(d, top);
          f[FL_A] = adj;
          if (it.kind != KIND_TEST) begin
            r.value = d;
            r.wr    = 1'b1;
          end
        end
        KIND_NEG: begin
          r.value = (data_t'(0) - a) & msk;
          r.wr    = 1'b1;
        end
        KIND_SHL, KIND_SHR, KIND_SAR: begin
          cnt  = (w == 64) ? 32'(it.second[5:0]) : 32'(it.second[4:0]);
          neg  = ((a & top) != '0);
          r.wr = 1'b1;
          if (cnt == 0) begin
            r.value = a;
          end else begin
            if (it.kind == KIND_SHL) begin
              r.value = (cnt >= w) ? '0 : ((a << cnt) & msk);
              d       = a >> (w - cnt);
              cf      = (cnt <= w) ? d[0] : 1'b0;
            end else begin
              d = a >> (cnt - 1);
              if (it.kind == KIND_SHR) begin
                r.value = a >> cnt;
                cf      = (cnt <= w) ? d[0] : 1'b0;
              end else begin
                if (cnt >= w) begin
                  r.value = neg ? msk : '0;
                end else begin
                  r.value = a >> cnt;
                  if (neg) r.value = r.value | (msk & ~(msk >> cnt));
                end
                cf = (cnt <= w) ? d[0] : neg;
              end
            end
            f[FL_C] = cf;
          end
        end
        default: begin
          if (jump_holds(it.kind, f)) begin
            r.taken  = 1'b1;
            r.target = it.rel ? (it.nip + it.second) : it.second;
          end
        end
      endcase
      held_flags = f;
      r.value    = r.value & msk;
      r.flags    = f;
      return r;
    endfunction

    function void note_instr(input instr_t it);
      awaited_results.push_back(execute(it));
    endfunction

    function void check_result(input alu_result_t got);
      alu_result_t exp;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %h wr %b taken %b target %h flags %b",
                   got.value, got.wr, got.taken, got.target, got.flags);
        return;
      end
      exp = awaited_results.pop_front();
      if (got.value !== exp.value || got.wr !== exp.wr || got.taken !== exp.taken ||
          got.target !== exp.target || got.flags !== exp.flags) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected value %h wr %b taken %b target %h flags %b,",
                    " got value %h wr %b taken %b target %h flags %b"},
                   exp.value, exp.wr, exp.taken, exp.target, exp.flags,
                   got.value, got.wr, got.taken, got.target, got.flags);
      end
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [KindW-1:0] in_kind;
  logic [SizeW-1:0] in_size_code;
  data_t            in_first_value;
  data_t            in_second_value;
  data_t            in_next_pointer;
  logic             in_relative;
  logic             out_valid;
  logic             out_ready;
  data_t            out_result_value;
  logic             out_write_result;
  logic             out_branch_taken;
  data_t            out_branch_target;
  flags_t           out_flags_out;

  alu_scoreboard board = new();

  // idling knobs, percent of cycles, changed per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // set by the stimulus to ask the receiver for one long hold-off
  logic        hold_request = 1'b0;
  int unsigned issued = 0;

  integer_alu_with_flags_and_branch dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_size_code      (in_size_code),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_next_pointer   (in_next_pointer),
    .in_relative       (in_relative),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_write_result  (out_write_result),
    .out_branch_taken  (out_branch_taken),
    .out_branch_target (out_branch_target),
    .out_flags_out     (out_flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the handshake locks up
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus one counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result beats are checked on the edge that accepts them
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result('{out_result_value, out_write_result, out_branch_taken,
                           out_branch_target, out_flags_out});
  end

  // drives one instruction beat, entered and left at a falling edge;
  // valid stays up when the next beat follows without a gap
  task automatic issue(input logic [KindW-1:0] kind, input logic [SizeW-1:0] size,
                       input data_t first, input data_t second, input data_t nip,
                       input logic rel);
    instr_t it;
    it = '{kind, size, first, second, nip, rel};
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_kind         = kind;
    in_size_code    = size;
    in_first_value  = first;
    in_second_value = second;
    in_next_pointer = nip;
    in_relative     = rel;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    board.note_instr(it);
    issued++;
    @(negedge clk);
  endtask

  // operands biased toward the sign and carry boundaries of each width
  function automatic data_t pick_operand();
    data_t v;
    case ($urandom_range(13))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'h1;
      3:       v = 64'h80;
      4:       v = 64'h7F;
      5:       v = 64'h8000;
      6:       v = 64'h7FFF;
      7:       v = 64'h8000_0000;
      8:       v = 64'h7FFF_FFFF;
      9:       v = {1'b1, 63'b0};
      10:      v = {1'b0, {63{1'b1}}};
      11:      v = data_t'($urandom_range(31));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // shift counts around the width, with junk above the count field
  function automatic data_t pick_count(input logic [SizeW-1:0] size);
    data_t       v;
    int unsigned w;
    int unsigned cnt;
    w = 8 << size;
    case ($urandom_range(5))
      0:       cnt = 0;
      1:       cnt = 1;
      2:       cnt = w - 1;
      3:       cnt = w;
      4:       cnt = w + 1;
      default: cnt = $urandom_range(63);
    endcase
    v      = {$urandom, $urandom};
    v[5:0] = cnt[5:0];
    return v;
  endfunction

  task automatic issue_random_op();
    logic [KindW-1:0] kind;
    logic [SizeW-1:0] size;
    data_t            first, second;
    kind  = KindW'($urandom_range(KIND_MOV, KIND_SAR));
    size  = SizeW'($urandom_range(SIZE_8, SIZE_64));
    first = pick_operand();
    if (kind == KIND_SHL || kind == KIND_SHR || kind == KIND_SAR)
      second = pick_count(size);
    else if ($urandom_range(4) == 0)
      second = first;  // equal operands make sub, cmp and xor yield zero
    else
      second = pick_operand();
    issue(kind, size, first, second, {$urandom, $urandom}, 1'($urandom_range(1)));
  endtask

  task automatic issue_random_jump();
    issue(KindW'($urandom_range(KIND_JMP, KIND_JG)), SizeW'($urandom_range(SIZE_8, SIZE_64)),
          {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
          1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned phase_end;
    in_valid        = 1'b0;
    in_kind         = KIND_MOV;
    in_size_code    = SIZE_8;
    in_first_value  = '0;
    in_second_value = '0;
    in_next_pointer = '0;
    in_relative     = 1'b0;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: flags clear after reset, so jz falls through
    issue(KIND_JZ,   SIZE_64, '0, 64'h40, 64'h1000, 1'b1);
    // byte add wraps to zero: carry, adjust, zero, parity
    issue(KIND_ADD,  SIZE_8,  64'hFF, 64'h01, 64'h1004, 1'b0);
    issue(KIND_JZ,   SIZE_8,  '0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h1008, 1'b1);
    issue(KIND_JBE,  SIZE_8,  '0, 64'h2000, 64'h100C, 1'b0);
    // signed overflow into the sign bit
    issue(KIND_ADD,  SIZE_8,  64'h7F, 64'h01, 64'h1010, 1'b0);
    issue(KIND_JL,   SIZE_8,  '0, 64'h3000, 64'h1014, 1'b0);
    issue(KIND_JGE,  SIZE_8,  '0, 64'h3000, 64'h1018, 1'b0);
    // sub borrows
    issue(KIND_SUB,  SIZE_16, '0, 64'h1, 64'h101C, 1'b0);
    issue(KIND_JB,   SIZE_16, '0, 64'h4000, 64'h1020, 1'b0);
    issue(KIND_JA,   SIZE_16, '0, 64'h4000, 64'h1024, 1'b0);
    // cmp of most negative and one overflows, no borrow
    issue(KIND_CMP,  SIZE_64, {1'b1, 63'b0}, 64'h1, 64'h1028, 1'b0);
    issue(KIND_JLE,  SIZE_64, '0, 64'h10, 64'h102C, 1'b1);
    issue(KIND_JG,   SIZE_64, '0, 64'h10, 64'h1030, 1'b1);
    // logic ops clear carry and overflow, keep adjust
    issue(KIND_AND,  SIZE_64, '1, '1, 64'h1034, 1'b0);
    issue(KIND_OR,   SIZE_16, 64'hFFFF_0000, 64'h0003_0000, 64'h1038, 1'b0);
    issue(KIND_XOR,  SIZE_32, 64'hDEAD_BEEF_1234_5678, 64'h0000_0000_1234_5678, 64'h103C, 1'b0);
    issue(KIND_TEST, SIZE_8,  64'h80, 64'hFF, 64'h1040, 1'b0);
    issue(KIND_JS,   SIZE_8,  '0, 64'h5000, 64'h1044, 1'b0);
    // move and negate leave the flags alone
    issue(KIND_MOV,  SIZE_16, '1, 64'h1234_5678, 64'h1048, 1'b0);
    issue(KIND_NEG,  SIZE_64, 64'h1, '0, 64'h104C, 1'b0);
    // shift counts: exactly the width, zero, past the width, one below the width
    issue(KIND_SHL,  SIZE_8,  64'h01, 64'h08, 64'h1050, 1'b0);
    issue(KIND_SHL,  SIZE_8,  64'h55, 64'hFFFF_FFFF_FFFF_FFC0, 64'h1054, 1'b0);
    issue(KIND_SHL,  SIZE_16, 64'hFFFF, 64'h11, 64'h1058, 1'b0);
    issue(KIND_SHR,  SIZE_64, '1, 64'h3F, 64'h105C, 1'b0);
    issue(KIND_SAR,  SIZE_8,  64'h80, 64'h14, 64'h1060, 1'b0);
    issue(KIND_SAR,  SIZE_32, 64'h8000_0000, 64'h1F, 64'h1064, 1'b0);
    // relative target wraps at 64 bits
    issue(KIND_JMP,  SIZE_64, '0, 64'h2, '1, 1'b1);
    // kinds past the jumps change nothing
    issue(KIND_IDLE_FIRST, SIZE_32, '1, '1, 64'h1068, 1'b1);
    issue(KIND_IDLE_LAST,  SIZE_64, '1, '1, 64'h106C, 1'b0);

    // random: flag-setting ops followed by the jumps that read them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 47; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      phase_end = issued + ItemsPerPhase;
      while (issued < phase_end) begin
        // each pass issues up to three beats, so the trigger is a window
        if (phase == 0 && issued + 240 >= phase_end && issued + 237 < phase_end)
          hold_request = 1'b1;
        if (phase == 1 && issued + 150 >= phase_end && issued + 147 < phase_end) begin
          // let the pipeline drain completely before going on
          in_valid = 1'b0;
          while (board.outstanding() != 0) @(negedge clk);
        end
        if ($urandom_range(49) == 0)
          issue(KindW'($urandom_range(KIND_IDLE_FIRST, KIND_IDLE_LAST)),
                SizeW'($urandom_range(SIZE_8, SIZE_64)),
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                1'($urandom_range(1)));
        else
          issue_random_op();
        repeat ($urandom_range(2)) issue_random_jump();
      end
    end

    in_valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    // keep the clock running so any stray beat is caught
    repeat (8) @(negedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== integer_alu_with_flags_and_branch.f =====
rtl/ialu_pkg.sv
rtl/integer_alu_with_flags_and_branch.sv
sim/integer_alu_with_flags_and_branch_test.sv
